[rtl/worst_fit_partition_allocator_top_macros.svh]
// assertion helpers for the allocator
`ifndef WORST_FIT_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// a holds in the same cycle as b
`define WFPA_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a in one cycle brings b in the next
`define WFPA_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`else

`define WFPA_ASSERT_SAME(label, clk, rst_n, a, b)
`define WFPA_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[rtl/wfpa_pkg.sv]
package wfpa_pkg;

	localparam int DEF_MAX_BLOCKS = 16;
	localparam int DEF_SIZE_BITS  = 16;
	localparam int SUM_W          = 20;

	localparam logic [1:0] ST_LOADED  = 2'd0;
	localparam logic [1:0] ST_GRANTED = 2'd1;
	localparam logic [1:0] ST_NOFIT   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// table commands from the sequencer
	typedef struct packed {
		logic load;
		logic grant;
		logic rd;
	} tbl_cmd_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		return (b > a) ? '0 : a - b;
	endfunction

endpackage

[rtl/worst_fit_partition_allocator_top.sv]
// worst-fit allocator over a table of fixed partitions
// load word: the load state writes the table entry, then the done strobe is shown
// allocate word: a scan that reads one table entry per cycle through the single
// size memory port and one shared compare unit, then the decide state and the strobe
// a new word may start in the cycle the done strobe is shown; the result is held
// arst_n clears the sequencer, counters, totals, refused flag and taken bits
module worst_fit_partition_allocator_top #(
	parameter int MAX_BLOCKS = wfpa_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = wfpa_pkg::DEF_SIZE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [15:0] request_size,
	input  logic [7:0]  request_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  block_index,
	output logic [15:0] leftover,
	output logic [19:0] internal_frag_total,
	output logic [19:0] free_space_total,
	output logic [4:0]  free_block_count,
	output logic        any_refused
);
	import wfpa_pkg::*;

	`include "worst_fit_partition_allocator_top_macros.svh"

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	// sequencer codes
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOAD   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;

	// latched input word
	logic                 op_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [7:0]           id_q;

	// table state and running totals
	logic [CW-1:0]    part_cnt_q;
	logic [CW-1:0]    free_cnt_q;
	logic [SUM_W-1:0] frag_sum_q;
	logic [SUM_W-1:0] free_sum_q;
	logic             refused_q;

	// scan pointer and read pipe
	logic [CW-1:0] ptr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// result registers
	logic          done_q;
	logic [1:0]    status_q;
	logic [IW-1:0] index_q;
	logic [15:0]   left_q;

	logic                 accept;
	logic                 issue;
	logic                 full;
	logic                 fits;
	tbl_cmd_t             cmd;
	logic [IW-1:0]        tbl_addr;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_taken_s1;
	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [SIZE_BITS-1:0] left_calc;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (part_cnt_q >= CW'(MAX_BLOCKS));
	// scan issues one read per cycle until every loaded entry is covered
	assign issue  = (state_q == S_SCAN) && (ptr_q < part_cnt_q);
	assign fits   = found_q && (size_q <= best_size_q);
	assign left_calc = best_size_q - size_q;

	// table commands: load writes at the fill point, grant marks the winner
	always_comb begin
		cmd.load  = (state_q == S_LOAD) && !full;
		cmd.grant = (state_q == S_DECIDE) && fits;
		cmd.rd    = issue;
		tbl_addr  = (state_q == S_LOAD) ? part_cnt_q[IW-1:0] : best_idx_q;
	end

	wfpa_table #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.addr       (tbl_addr),
		.wdata      (size_q),
		.wid        (id_q),
		.rd_addr    (ptr_q[IW-1:0]),
		.rd_data_s1 (rd_data_s1),
		.rd_taken_s1(rd_taken_s1)
	);

	wfpa_best #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.vld_s1     (vld_s1),
		.idx_s1     (idx_s1),
		.data_s1    (rd_data_s1),
		.taken_s1   (rd_taken_s1),
		.found_q    (found_q),
		.best_idx_q (best_idx_q),
		.best_size_q(best_size_q)
	);

	// latch the accepted word, sizes cut to SIZE_BITS
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			size_q <= SIZE_BITS'(request_size);
			id_q   <= request_id;
		end
		if (issue) begin
			idx_s1 <= ptr_q[IW-1:0];
		end
	end

	// sequencer, totals and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			part_cnt_q <= '0;
			free_cnt_q <= '0;
			frag_sum_q <= '0;
			free_sum_q <= '0;
			refused_q  <= 1'b0;
			ptr_q      <= '0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ptr_q   <= '0;
						state_q <= operation ? S_SCAN : S_LOAD;
					end
				end
				S_LOAD: begin
					if (!full) begin
						part_cnt_q <= part_cnt_q + CW'(1);
						free_cnt_q <= free_cnt_q + CW'(1);
						free_sum_q <= sat_add(free_sum_q, SUM_W'(size_q));
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						// last read is folded in by the compare unit at this edge
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fits) begin
						frag_sum_q <= sat_add(frag_sum_q, SUM_W'(left_calc));
						free_sum_q <= sat_sub(free_sum_q, SUM_W'(best_size_q));
						if (free_cnt_q != '0) begin
							free_cnt_q <= free_cnt_q - CW'(1);
						end
					end else begin
						refused_q <= 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, held until the next word finishes
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			status_q <= full ? ST_FULL : ST_LOADED;
			index_q  <= full ? '0 : part_cnt_q[IW-1:0];
			left_q   <= '0;
		end else if (state_q == S_DECIDE) begin
			status_q <= fits ? ST_GRANTED : ST_NOFIT;
			index_q  <= fits ? best_idx_q : '0;
			left_q   <= fits ? 16'(left_calc) : '0;
		end
	end

	assign done                = done_q;
	assign status              = status_q;
	assign block_index         = 4'(index_q);
	assign leftover            = left_q;
	assign internal_frag_total = frag_sum_q;
	assign free_space_total    = free_sum_q;
	assign free_block_count    = 5'(free_cnt_q);
	assign any_refused         = refused_q;

	// accepted word keeps the block busy on the next cycle
	`WFPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	// a grant takes exactly one partition off the free count
	`WFPA_ASSERT_SAME(a_grant_count, clk, arst_n, done_q && (status_q == ST_GRANTED), free_cnt_q == $past(free_cnt_q) - CW'(1))
	// table full is only reported with every slot loaded
	`WFPA_ASSERT_SAME(a_full_cnt, clk, arst_n, done_q && (status_q == ST_FULL), part_cnt_q == CW'(MAX_BLOCKS))
	// refused flag never clears
	`WFPA_ASSERT_NEXT(a_refused_sticky, clk, arst_n, refused_q, refused_q)
	// a load is only taken from the idle state with the op latched as load
	`WFPA_ASSERT_SAME(a_load_op, clk, arst_n, state_q == S_LOAD, !op_q)

endmodule

[rtl/wfpa_table.sv]
module wfpa_table #(
	parameter int MAX_BLOCKS = wfpa_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = wfpa_pkg::DEF_SIZE_BITS,
	localparam int IW        = $clog2(MAX_BLOCKS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfpa_pkg::tbl_cmd_t   cmd,
	input  logic [IW-1:0]        addr,
	input  logic [SIZE_BITS-1:0] wdata,
	input  logic [7:0]           wid,
	input  logic [IW-1:0]        rd_addr,
	output logic [SIZE_BITS-1:0] rd_data_s1,
	output logic                 rd_taken_s1
);
	import wfpa_pkg::*;

	logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
	logic [7:0]           owner_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] taken_q;

	// size and owner memories, registered read port
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_mem[addr] <= wdata;
		end
		if (cmd.grant) begin
			owner_mem[addr] <= wid;
		end
		if (cmd.rd) begin
			rd_data_s1  <= size_mem[rd_addr];
			rd_taken_s1 <= taken_q[rd_addr];
		end
	end

	// taken bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else begin
			if (cmd.load) begin
				taken_q[addr] <= 1'b0;
			end
			if (cmd.grant) begin
				taken_q[addr] <= 1'b1;
			end
		end
	end

endmodule

[rtl/wfpa_best.sv]
module wfpa_best #(
	parameter int MAX_BLOCKS = wfpa_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = wfpa_pkg::DEF_SIZE_BITS,
	localparam int IW        = $clog2(MAX_BLOCKS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 vld_s1,
	input  logic [IW-1:0]        idx_s1,
	input  logic [SIZE_BITS-1:0] data_s1,
	input  logic                 taken_s1,
	output logic                 found_q,
	output logic [IW-1:0]        best_idx_q,
	output logic [SIZE_BITS-1:0] best_size_q
);
	import wfpa_pkg::*;

	logic take;

	// strictly larger wins, so ties keep the lowest position
	assign take = vld_s1 && !taken_s1 && (!found_q || (data_s1 > best_size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clear) begin
			best_idx_q  <= idx_s1;
			best_size_q <= data_s1;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import wfpa_pkg::*;

	// table geometry follows the block's defaults
	localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;

	// operation codes carried by the operation port
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_ALLOCATE = 1'b1;

	// no free partition in the table
	localparam int NO_FREE = -1;

	// an allocate word scans every loaded entry, so allow a generous quiet stretch
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_LIMIT  = 200;

	// one result word as the block reports it
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  block_index;
		logic [15:0] leftover;
		logic [19:0] frag_total;
		logic [19:0] free_total;
		logic [4:0]  free_count;
		logic        refused;
	} alloc_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        operation = 1'b0;
	logic [15:0] request_size = '0;
	logic [7:0]  request_id = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [3:0]  block_index;
	logic [15:0] leftover;
	logic [19:0] internal_frag_total;
	logic [19:0] free_space_total;
	logic [4:0]  free_block_count;
	logic        any_refused;

	worst_fit_partition_allocator_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.operation           (operation),
		.request_size        (request_size),
		.request_id          (request_id),
		.done                (done),
		.status              (status),
		.block_index         (block_index),
		.leftover            (leftover),
		.internal_frag_total (internal_frag_total),
		.free_space_total    (free_space_total),
		.free_block_count    (free_block_count),
		.any_refused         (any_refused)
	);

	always #5 clk = ~clk;

	// predicted partition table, updated as each word is accepted
	logic [15:0] part_size_q [TABLE_DEPTH];
	logic        part_taken_q [TABLE_DEPTH] = '{default: 1'b0};
	int          part_count_q = 0;
	logic [19:0] frag_sum_q = '0;
	logic [19:0] free_sum_q = '0;
	logic [4:0]  free_count_q = '0;
	logic        refused_q = 1'b0;

	// results still owed by the block, oldest first
	alloc_word_t pending_results [$];

	int mismatches = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	// largest free partition, lowest position on a tie
	function automatic int widest_free_index();
		int best;
		best = NO_FREE;
		for (int i = 0; i < part_count_q; i++)
			if (!part_taken_q[i] && (best == NO_FREE || part_size_q[i] > part_size_q[best]))
				best = i;
		return best;
	endfunction

	// advance the predicted table by one word and return the result it should give
	function automatic alloc_word_t predict_allocation(logic op, logic [15:0] size);
		alloc_word_t w;
		int best;
		logic [20:0] sum;
		w = '0;
		if (op == OP_LOAD) begin
			if (part_count_q >= TABLE_DEPTH) begin
				// table full: nothing changes, refused flag untouched
				w.status = ST_FULL;
			end else begin
				w.status = ST_LOADED;
				w.block_index = 4'(part_count_q);
				part_size_q[part_count_q] = size;
				part_taken_q[part_count_q] = 1'b0;
				part_count_q++;
				sum = {1'b0, free_sum_q} + 21'(size);
				free_sum_q = sum[20] ? '1 : sum[19:0];
				free_count_q++;
			end
		end else begin
			best = widest_free_index();
			// a zero-size request fits any free partition
			if (best != NO_FREE && size <= part_size_q[best]) begin
				w.status = ST_GRANTED;
				w.block_index = 4'(best);
				w.leftover = part_size_q[best] - size;
				part_taken_q[best] = 1'b1;
				sum = {1'b0, frag_sum_q} + 21'(w.leftover);
				frag_sum_q = sum[20] ? '1 : sum[19:0];
				free_sum_q = (20'(part_size_q[best]) > free_sum_q) ? '0
					: free_sum_q - 20'(part_size_q[best]);
				if (free_count_q != 0)
					free_count_q--;
			end else begin
				// empty table, all granted, or request too large
				w.status = ST_NOFIT;
				refused_q = 1'b1;
			end
		end
		w.frag_total = frag_sum_q;
		w.free_total = free_sum_q;
		w.free_count = free_count_q;
		w.refused = refused_q;
		return w;
	endfunction

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [19:0] got, logic [19:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// drive one word, hold it until accepted, then book its expected result
	task automatic send_word(logic op, logic [15:0] size, logic [7:0] id);
		start <= 1'b1;
		operation <= op;
		request_size <= size;
		request_id <= id;
		// busy read here is its value just before the edge
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_allocation(op, size));
	endtask

	// sender gap with start low, now and then
	task automatic maybe_idle();
		if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// random word: sizes lean on ties, extremes and the current largest free partition
	task automatic send_random_word();
		logic op;
		logic [15:0] size;
		int best;
		int pick;
		op = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (op == OP_LOAD) begin
			if (pick < 4)
				size = 16'($urandom_range(0, 65535));
			else if (pick < 7)
				size = 16'(100 * $urandom_range(1, 3));
			else if (pick == 7)
				size = 16'h0000;
			else if (pick == 8)
				size = 16'hFFFF;
			else
				size = 16'($urandom_range(0, 15));
		end else begin
			best = widest_free_index();
			if (best == NO_FREE)
				size = 16'($urandom_range(0, 65535));
			else if (pick < 6)
				size = 16'($urandom_range(0, part_size_q[best]));
			else if (pick < 8)
				size = part_size_q[best];
			else if (pick == 8)
				size = 16'h0000;
			else if (part_size_q[best] == 16'hFFFF)
				size = 16'($urandom_range(0, 65535));
			else
				size = part_size_q[best] + 16'd1;
		end
		send_word(op, size, 8'($urandom_range(0, 255)));
	endtask

	// allocate on an empty table: refused, sticky flag set
	task automatic test_empty_table();
		send_word(OP_ALLOCATE, 16'h0000, 8'h00);
		send_word(OP_ALLOCATE, 16'hFFFF, 8'hFF);
	endtask

	// smallest and largest sizes, plus a pair of equal sizes for the tie rule
	task automatic test_load_extremes();
		send_word(OP_LOAD, 16'h0000, 8'hA5);
		send_word(OP_LOAD, 16'hFFFF, 8'h5A);
		send_word(OP_LOAD, 16'd300, 8'hFF);
		send_word(OP_LOAD, 16'd300, 8'h00);
	endtask

	// exact fit, zero-size request, tie to lowest position, too large, all granted
	task automatic test_worst_fit_choice();
		send_word(OP_ALLOCATE, 16'hFFFF, 8'hFF);
		send_word(OP_ALLOCATE, 16'h0000, 8'h00);
		send_word(OP_ALLOCATE, 16'd301, 8'h3C);
		send_word(OP_ALLOCATE, 16'd300, 8'hC3);
		send_word(OP_ALLOCATE, 16'h0000, 8'h81);
		send_word(OP_ALLOCATE, 16'h0000, 8'h7E);
	endtask

	// random loads and allocates until the table has no room left
	task automatic test_random_fill();
		while (part_count_q < TABLE_DEPTH) begin
			maybe_idle();
			send_random_word();
		end
	endtask

	// loads into a full table change nothing and do not set the refused flag; then a zero-size allocate
	task automatic test_table_full();
		send_word(OP_LOAD, 16'hFFFF, 8'hFF);
		send_word(OP_LOAD, 16'h0000, 8'h00);
		send_word(OP_ALLOCATE, 16'h0000, 8'h42);
	endtask

	// random traffic with sender gaps now and then
	task automatic test_random_traffic();
		repeat (300) begin
			maybe_idle();
			send_random_word();
		end
	endtask

	// back-to-back words, start held high throughout
	task automatic test_back_to_back();
		repeat (70)
			send_random_word();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_load_extremes();
		test_worst_fit_choice();
		test_random_fill();
		test_table_full();
		test_random_traffic();
		test_back_to_back();
		start <= 1'b0;
		// wait out every owed result, then a tail for stray strobes
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// each strobed result against the oldest expectation, field by field
	always @(posedge clk) begin : check_results
		alloc_word_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 20'(status), 20'(want.status));
				compare_field("block_index", 20'(block_index), 20'(want.block_index));
				compare_field("leftover", 20'(leftover), 20'(want.leftover));
				compare_field("internal_frag_total", internal_frag_total, want.frag_total);
				compare_field("free_space_total", free_space_total, want.free_total);
				compare_field("free_block_count", 20'(free_block_count), 20'(want.free_count));
				compare_field("any_refused", 20'(any_refused), 20'(want.refused));
			end
		end
	end

	// watchdog: too many cycles with no word accepted and no result strobed
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
